[design/wrh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water ripple height field: shared package
// Defaults, field widths, operation and register codes, and the controller
// state type used by the ripple height field block.
// ----------------------------------------------------------------------------
package wrh_pkg;

  // Default geometry and height width.
  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 128;
  localparam int HEIGHT_BITS_DEF  = 9;

  // Fixed field widths of the stream and configuration beats.
  localparam int OP_BITS     = 2;
  localparam int POS_BITS    = 7;
  localparam int OUT_H_BITS  = 9;
  localparam int DROP_BITS   = 9;
  localparam int DAMP_BITS   = 4;
  localparam int CFG_IDX_BITS = 1;

  // Signed coordinate width, wide enough for any frame size and any position.
  localparam int COORD_BITS = 14;

  // Register reset values.
  localparam logic signed [DROP_BITS-1:0] DROP_STRENGTH_RESET = 9'sd255;
  localparam logic [DAMP_BITS-1:0]        DAMP_SHIFT_RESET    = 4'd4;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_DROP = 2'd0;
  localparam logic [OP_BITS-1:0] OP_STEP = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DROP_STRENGTH = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMP_SHIFT    = 1'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DROP,
    ST_STEP,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

[design/water_ripple_height_field.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water ripple height field
// Two-buffer ripple simulation: drops, damped simulation steps and height
// reads over a frame of signed heights held in two synchronous memories.
// ----------------------------------------------------------------------------
// After reset the block zeroes both height memories, one entry per cycle, and
// accepts no beat until that pass is over; configuration writes are taken at
// any time. A drop beat visits the nine cells of the 3x3 block and writes
// those inside the frame. A step beat sweeps the frame: the sweep reads one
// cell of each buffer per cycle, neighbors come from a two-row line shift,
// and the new value passes the memory read register and the update stage
// register before it is written back to the current buffer. One result beat
// leaves per input beat, through an output register, so a stalled result
// does not block the next input.
// ----------------------------------------------------------------------------
module water_ripple_height_field #(
  parameter int FRAME_WIDTH  = wrh_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = wrh_pkg::FRAME_HEIGHT_DEF,
  parameter int HEIGHT_BITS  = wrh_pkg::HEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] x_pos, [13:7] y_pos, [15:14] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] read_height, [15:9] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] done_op
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wrh_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CELLS     = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam int XB        = $clog2(FRAME_WIDTH);
  localparam int YB        = $clog2(FRAME_HEIGHT);
  localparam int CB        = wrh_pkg::COORD_BITS;
  localparam int SHIFT_LEN = 2 * FRAME_WIDTH;
  localparam int OB        = wrh_pkg::OUT_H_BITS;
  localparam int EXT       = (HEIGHT_BITS > OB) ? HEIGHT_BITS : OB;
  localparam int WB        = ((HEIGHT_BITS > wrh_pkg::DROP_BITS) ?
                              HEIGHT_BITS : wrh_pkg::DROP_BITS) + 1;
  localparam logic signed [WB-1:0] DMAX = WB'((2 ** (HEIGHT_BITS - 1)) - 1);
  localparam logic signed [WB-1:0] DMIN = -DMAX - WB'(1);

  // Control and configuration state.
  wrh_pkg::state_t state, state_next;
  logic                                   current_is_a;
  logic signed [wrh_pkg::DROP_BITS-1:0]   drop_strength;
  logic [wrh_pkg::DAMP_BITS-1:0]          damp_shift;
  logic [wrh_pkg::OP_BITS-1:0]            op_q;
  logic [wrh_pkg::POS_BITS-1:0]           x_q;
  logic [wrh_pkg::POS_BITS-1:0]           y_q;
  logic [ADDR_BITS-1:0]                   clr_addr;
  logic [ADDR_BITS-1:0]                   idx;
  logic [XB-1:0]                          ix;
  logic [YB-1:0]                          iy;
  logic [1:0]                             dxi;
  logic [1:0]                             dyi;
  logic                                   p1_valid;
  logic                                   p1_int;
  logic [ADDR_BITS-1:0]                   p1_addr;

  // Height memories and their registered read data.
  logic signed [HEIGHT_BITS-1:0] mem_a [CELLS];
  logic signed [HEIGHT_BITS-1:0] mem_b [CELLS];
  logic signed [HEIGHT_BITS-1:0] rdata_a;
  logic signed [HEIGHT_BITS-1:0] rdata_b;

  // Line shift of the previous buffer for the neighbor taps.
  logic signed [HEIGHT_BITS-1:0] sh [SHIFT_LEN];

  // Combinational control.
  logic                          in_accept;
  logic                          out_load;
  logic                          clearing;
  logic                          cur_we;
  logic [ADDR_BITS-1:0]          cur_waddr;
  logic signed [HEIGHT_BITS-1:0] cur_wdata;
  logic                          cur_re;
  logic [ADDR_BITS-1:0]          cur_raddr;
  logic                          prev_re;
  logic [ADDR_BITS-1:0]          prev_raddr;
  logic                          a_we, b_we, a_re, b_re;
  logic [ADDR_BITS-1:0]          a_waddr, b_waddr, a_raddr, b_raddr;
  logic signed [HEIGHT_BITS-1:0] a_wdata, b_wdata;
  logic signed [HEIGHT_BITS-1:0] prev_rdata, cur_rdata;

  // Address arithmetic for drops and reads.
  logic [CB-1:0]                 drop_cx, drop_cy;
  logic                          drop_in_frame;
  logic [ADDR_BITS-1:0]          drop_addr;
  logic signed [WB-1:0]          drop_ext;
  logic signed [HEIGHT_BITS-1:0] drop_h;
  logic                          read_in_frame;
  logic [ADDR_BITS-1:0]          read_addr;
  logic                          step_interior;
  logic signed [EXT-1:0]         read_ext;
  logic [OB-1:0]                 result_height;

  // Update datapath outputs.
  logic                          upd_busy;
  logic                          upd_we;
  logic [ADDR_BITS-1:0]          upd_addr;
  logic signed [HEIGHT_BITS-1:0] upd_data;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // Drop cell coordinates and saturated drop height.
  always_comb begin
    drop_cx = CB'(x_q) + CB'(dxi) - CB'(1);
    drop_cy = CB'(y_q) + CB'(dyi) - CB'(1);
    drop_in_frame = !drop_cx[CB-1] && !drop_cy[CB-1] &&
                    (drop_cx < CB'(FRAME_WIDTH)) && (drop_cy < CB'(FRAME_HEIGHT));
    drop_addr = ADDR_BITS'(ADDR_BITS'(drop_cy) * ADDR_BITS'(FRAME_WIDTH) +
                           ADDR_BITS'(drop_cx));
    drop_ext = WB'(drop_strength);
    if (drop_ext > DMAX) begin
      drop_h = DMAX[HEIGHT_BITS-1:0];
    end else if (drop_ext < DMIN) begin
      drop_h = DMIN[HEIGHT_BITS-1:0];
    end else begin
      drop_h = drop_ext[HEIGHT_BITS-1:0];
    end
  end

  // Read address and bounds.
  always_comb begin
    read_in_frame = (CB'(x_q) < CB'(FRAME_WIDTH)) && (CB'(y_q) < CB'(FRAME_HEIGHT));
    read_addr = ADDR_BITS'(ADDR_BITS'(y_q) * ADDR_BITS'(FRAME_WIDTH) + ADDR_BITS'(x_q));
  end

  // The center of the sweep trails the read position by one row.
  assign step_interior = (iy >= YB'(2)) && (ix >= XB'(1)) &&
                         (ix <= XB'(FRAME_WIDTH - 2));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wrh_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_BITS'(CELLS - 1)) state_next = wrh_pkg::ST_IDLE;
      end
      wrh_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            wrh_pkg::OP_DROP: state_next = wrh_pkg::ST_DROP;
            wrh_pkg::OP_STEP: state_next = wrh_pkg::ST_STEP;
            wrh_pkg::OP_READ: state_next = wrh_pkg::ST_READ;
            default:          state_next = wrh_pkg::ST_FINISH;
          endcase
        end
      end
      wrh_pkg::ST_DROP: begin
        if (dxi == 2'd2 && dyi == 2'd2) state_next = wrh_pkg::ST_FINISH;
      end
      wrh_pkg::ST_STEP: begin
        if (idx == ADDR_BITS'(CELLS - 1)) state_next = wrh_pkg::ST_DRAIN;
      end
      wrh_pkg::ST_DRAIN: begin
        if (!p1_valid && !upd_busy) state_next = wrh_pkg::ST_FINISH;
      end
      wrh_pkg::ST_READ: begin
        state_next = wrh_pkg::ST_FINISH;
      end
      wrh_pkg::ST_FINISH: begin
        if (out_load) state_next = wrh_pkg::ST_IDLE;
      end
      default: state_next = wrh_pkg::ST_CLEAR;
    endcase
  end

  // State outputs: handshake and memory port controls by buffer role.
  always_comb begin
    s_axis_tready = 1'b0;
    clearing      = 1'b0;
    out_load      = 1'b0;
    cur_we        = upd_we;
    cur_waddr     = upd_addr;
    cur_wdata     = upd_data;
    cur_re        = 1'b0;
    cur_raddr     = ADDR_BITS'(idx - ADDR_BITS'(FRAME_WIDTH));
    prev_re       = 1'b0;
    prev_raddr    = idx;
    case (state)
      wrh_pkg::ST_CLEAR: begin
        clearing = 1'b1;
      end
      wrh_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      wrh_pkg::ST_DROP: begin
        cur_we    = drop_in_frame;
        cur_waddr = drop_addr;
        cur_wdata = drop_h;
      end
      wrh_pkg::ST_STEP: begin
        cur_re  = 1'b1;
        prev_re = 1'b1;
      end
      wrh_pkg::ST_READ: begin
        prev_re    = 1'b1;
        prev_raddr = read_addr;
      end
      wrh_pkg::ST_FINISH: begin
        out_load = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // Map current and previous roles onto the two memories.
  always_comb begin
    a_we    = clearing || (cur_we && current_is_a);
    b_we    = clearing || (cur_we && !current_is_a);
    a_waddr = clearing ? clr_addr : cur_waddr;
    b_waddr = clearing ? clr_addr : cur_waddr;
    a_wdata = clearing ? '0 : cur_wdata;
    b_wdata = clearing ? '0 : cur_wdata;
    a_re    = current_is_a ? cur_re : prev_re;
    b_re    = current_is_a ? prev_re : cur_re;
    a_raddr = current_is_a ? cur_raddr : prev_raddr;
    b_raddr = current_is_a ? prev_raddr : cur_raddr;
    prev_rdata = current_is_a ? rdata_b : rdata_a;
    cur_rdata  = current_is_a ? rdata_a : rdata_b;
  end

  // Height memory A.
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (a_re) rdata_a <= mem_a[a_raddr];
  end

  // Height memory B.
  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    if (b_re) rdata_b <= mem_b[b_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wrh_pkg::ST_CLEAR;
      current_is_a <= 1'b1;
      clr_addr     <= '0;
      p1_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == wrh_pkg::ST_STEP);
      if (clearing) clr_addr <= ADDR_BITS'(clr_addr + ADDR_BITS'(1));
      if (state == wrh_pkg::ST_DRAIN && state_next == wrh_pkg::ST_FINISH) begin
        current_is_a <= !current_is_a;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_strength <= wrh_pkg::DROP_STRENGTH_RESET;
      damp_shift    <= wrh_pkg::DAMP_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wrh_pkg::REG_DROP_STRENGTH: drop_strength <= cfg_data;
        wrh_pkg::REG_DAMP_SHIFT:    damp_shift    <= cfg_data[wrh_pkg::DAMP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture, sweep counters and drop offsets.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q <= s_axis_tuser;
      x_q  <= s_axis_tdata[wrh_pkg::POS_BITS-1:0];
      y_q  <= s_axis_tdata[2*wrh_pkg::POS_BITS-1:wrh_pkg::POS_BITS];
      idx  <= '0;
      ix   <= '0;
      iy   <= '0;
      dxi  <= '0;
      dyi  <= '0;
    end
    if (state == wrh_pkg::ST_STEP) begin
      idx <= ADDR_BITS'(idx + ADDR_BITS'(1));
      if (ix == XB'(FRAME_WIDTH - 1)) begin
        ix <= '0;
        iy <= YB'(iy + YB'(1));
      end else begin
        ix <= XB'(ix + XB'(1));
      end
    end
    if (state == wrh_pkg::ST_DROP) begin
      if (dxi == 2'd2) begin
        dxi <= '0;
        dyi <= dyi + 2'd1;
      end else begin
        dxi <= dxi + 2'd1;
      end
    end
    p1_int  <= step_interior;
    p1_addr <= cur_raddr;
  end

  // Line shift: one previous-buffer cell enters per sweep cycle.
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      sh[0] <= prev_rdata;
      for (int k = 1; k < SHIFT_LEN; k++) begin
        sh[k] <= sh[k-1];
      end
    end
  end

  wrh_cell_update #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (p1_valid && p1_int),
    .in_addr    (p1_addr),
    .up         (sh[SHIFT_LEN-1]),
    .down       (prev_rdata),
    .left       (sh[FRAME_WIDTH]),
    .right      (sh[FRAME_WIDTH-2]),
    .cur        (cur_rdata),
    .damp_shift (damp_shift),
    .busy       (upd_busy),
    .wr_en      (upd_we),
    .wr_addr    (upd_addr),
    .wr_data    (upd_data)
  );

  // Result value: only reads inside the frame return a height.
  always_comb begin
    read_ext = EXT'(prev_rdata);
    if (op_q == wrh_pkg::OP_READ && read_in_frame) begin
      result_height = read_ext[OB-1:0];
    end else begin
      result_height = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= 16'(result_height);
      m_axis_tuser <= op_q;
    end
  end

`ifndef NO_ASSERTIONS
  // The buffers swap roles only at the end of a step sweep.
  a_swap_at_drain: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (current_is_a != $past(current_is_a))) |->
      ($past(state) == wrh_pkg::ST_DRAIN))
    else $error("buffer roles swapped outside the end of a step");

  // The update pipeline is empty whenever a new beat can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == wrh_pkg::ST_IDLE) |-> (!p1_valid && !upd_busy))
    else $error("update pipeline busy while idle");

  // Update writes only land during a step sweep or its drain.
  a_upd_in_step: assert property (@(posedge clk) disable iff (rst)
    upd_we |-> (state == wrh_pkg::ST_STEP || state == wrh_pkg::ST_DRAIN))
    else $error("cell update write outside a step");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("pending result overwritten");
`endif

endmodule

[design/wrh_cell_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water ripple cell update
// Two-stage datapath that turns the four neighbors of a cell in the previous
// buffer and its own value in the current buffer into the new damped,
// saturated height, presented as a write to the current buffer.
// ----------------------------------------------------------------------------
module wrh_cell_update #(
  parameter int HEIGHT_BITS = wrh_pkg::HEIGHT_BITS_DEF,
  parameter int ADDR_BITS   = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ADDR_BITS-1:0]          in_addr,
  input  logic signed [HEIGHT_BITS-1:0] up,
  input  logic signed [HEIGHT_BITS-1:0] down,
  input  logic signed [HEIGHT_BITS-1:0] left,
  input  logic signed [HEIGHT_BITS-1:0] right,
  input  logic signed [HEIGHT_BITS-1:0] cur,
  input  logic [wrh_pkg::DAMP_BITS-1:0] damp_shift,
  output logic                          busy,
  output logic                          wr_en,
  output logic [ADDR_BITS-1:0]          wr_addr,
  output logic signed [HEIGHT_BITS-1:0] wr_data
);

  localparam int SB = HEIGHT_BITS + 2;
  localparam int VB = HEIGHT_BITS + 3;
  localparam int DB = VB + 1;
  localparam logic signed [DB-1:0] HMAX = DB'((2 ** (HEIGHT_BITS - 1)) - 1);
  localparam logic signed [DB-1:0] HMIN = -HMAX - DB'(1);

  logic signed [SB-1:0] sum;
  logic signed [SB-1:0] sum_adj;
  logic signed [SB-1:0] half;
  logic signed [VB-1:0] v1_next;

  logic                 p2_valid;
  logic [ADDR_BITS-1:0] p2_addr;
  logic signed [VB-1:0] v1;

  logic signed [VB-1:0] damp;
  logic signed [DB-1:0] diff;

  // Stage one: neighbor sum halved toward zero, minus the cell's own value.
  always_comb begin
    sum     = SB'(up) + SB'(down) + SB'(left) + SB'(right);
    sum_adj = sum + $signed({{(SB-1){1'b0}}, sum[SB-1]});
    half    = sum_adj >>> 1;
    v1_next = VB'(half) - VB'(cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    v1      <= v1_next;
    p2_addr <= in_addr;
  end

  // Stage two: remove the damping fraction and clamp to the height range.
  always_comb begin
    damp = v1 >>> damp_shift;
    diff = DB'(v1) - DB'(damp);
    if (diff > HMAX) begin
      wr_data = HMAX[HEIGHT_BITS-1:0];
    end else if (diff < HMIN) begin
      wr_data = HMIN[HEIGHT_BITS-1:0];
    end else begin
      wr_data = diff[HEIGHT_BITS-1:0];
    end
  end

  assign wr_en   = p2_valid;
  assign wr_addr = p2_addr;
  assign busy    = p2_valid;

endmodule
